/* rtl/sbq_pkg.sv */
// Package for the start button qualifier: widths, codes, reset values and
// the structs shared by the threshold registers, the core and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sbq_pkg;

    // Fixed widths of the configuration registers and derived thresholds.
    localparam int CFG_W     = 16;
    localparam int US_PER_MS = 1000;
    // 65535 ms * 1000 fits in 26 bits.
    localparam int THR_W     = 26;
    localparam int IDX_W     = 2;
    localparam int TIME_BITS_DEF = 48;

    // Result payload: start_event, debounced_pressed, is_armed, padded to a byte.
    localparam int OUT_W = 8;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_PRESS_DEBOUNCE = 2'd0;
    localparam logic [IDX_W-1:0] REG_STARTUP_GUARD  = 2'd1;
    localparam logic [IDX_W-1:0] REG_RELEASE_REARM  = 2'd2;

    // Reset values of the registers, already scaled to microseconds.
    localparam logic [THR_W-1:0] PRESS_DEBOUNCE_RST_US = THR_W'(20 * US_PER_MS);
    localparam logic [THR_W-1:0] STARTUP_GUARD_RST_US  = THR_W'(500 * US_PER_MS);
    localparam logic [THR_W-1:0] RELEASE_REARM_RST_US  = THR_W'(100 * US_PER_MS);

    // Command codes carried in tuser.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_START  = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0] debounce_us;
        logic [THR_W-1:0] guard_us;
        logic [THR_W-1:0] rearm_us;
    } t_thresh;

    typedef struct packed {
        logic is_armed;
        logic debounced_pressed;
        logic start_event;
    } t_result;

endpackage

`default_nettype wire

/* rtl/sbq_cfg.sv */
// Configuration registers of the start button qualifier. Each write stores
// the millisecond value already scaled to microseconds. Depends on sbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbq_cfg (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [sbq_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire  [sbq_pkg::CFG_W-1:0]      i_cfg_wdata,
    output sbq_pkg::t_thresh               o_thresh
);

    sbq_pkg::t_thresh            r_thresh;
    logic [sbq_pkg::THR_W-1:0]   w_scaled;

    // Constant multiply by 1000; the product goes straight into the threshold register on a write.
    assign w_scaled = sbq_pkg::THR_W'(i_cfg_wdata) * sbq_pkg::THR_W'(sbq_pkg::US_PER_MS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.debounce_us <= sbq_pkg::PRESS_DEBOUNCE_RST_US;
            r_thresh.guard_us    <= sbq_pkg::STARTUP_GUARD_RST_US;
            r_thresh.rearm_us    <= sbq_pkg::RELEASE_REARM_RST_US;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbq_pkg::REG_PRESS_DEBOUNCE: r_thresh.debounce_us <= w_scaled;
                sbq_pkg::REG_STARTUP_GUARD:  r_thresh.guard_us    <= w_scaled;
                sbq_pkg::REG_RELEASE_REARM:  r_thresh.rearm_us    <= w_scaled;
                default: ;
            endcase
        end
    end

    assign o_thresh = r_thresh;

endmodule

`default_nettype wire

/* rtl/sbq_core.sv */
// Qualification state and its single-pass update for one sample or start
// command. Depends on sbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbq_core #(
    parameter int TIME_BITS = sbq_pkg::TIME_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_adv,
    input  wire                    i_cmd,
    input  wire                    i_lvl,
    input  wire  [TIME_BITS-1:0]   i_now,
    input  wire  sbq_pkg::t_thresh i_thresh,
    output sbq_pkg::t_result       o_result
);

    logic                 r_started, n_started;
    logic                 r_raw, n_raw;
    logic                 r_stable, n_stable;
    logic                 r_armed, n_armed;
    logic                 r_pending, n_pending;
    logic [TIME_BITS-1:0] r_raw_time, n_raw_time;
    logic [TIME_BITS-1:0] r_stable_time, n_stable_time;
    logic [TIME_BITS-1:0] r_start_time, n_start_time;

    logic [TIME_BITS-1:0] w_d_raw, w_d_stable, w_d_start;
    logic [TIME_BITS-1:0] w_deb, w_guard, w_rearm;
    logic w_changed, w_e_deb, w_e_guard, w_e_rearm, w_flip, w_disarm, w_event;

    localparam int PAD_W = TIME_BITS - sbq_pkg::THR_W;

    assign w_deb   = {{PAD_W{1'b0}}, i_thresh.debounce_us};
    assign w_guard = {{PAD_W{1'b0}}, i_thresh.guard_us};
    assign w_rearm = {{PAD_W{1'b0}}, i_thresh.rearm_us};

    // Differences wrap naturally at TIME_BITS.
    assign w_d_raw    = i_now - r_raw_time;
    assign w_d_stable = i_now - r_stable_time;
    assign w_d_start  = i_now - r_start_time;

    // A raw change restarts its timer at now, so only a zero debounce passes.
    assign w_changed = (i_lvl != r_raw);
    assign w_e_deb   = w_changed ? (i_thresh.debounce_us == '0) : (w_d_raw >= w_deb);
    assign w_e_guard = (w_d_start >= w_guard);
    assign w_flip    = (i_lvl != r_stable) && w_e_deb;
    assign w_disarm  = w_flip && i_lvl && r_armed;
    // Likewise a stable change on this sample restarts the rearm timer.
    assign w_e_rearm = w_flip ? (i_thresh.rearm_us == '0) : (w_d_stable >= w_rearm);

    always_comb begin
        n_started     = r_started;
        n_raw         = r_raw;
        n_stable      = r_stable;
        n_armed       = r_armed;
        n_pending     = r_pending;
        n_raw_time    = r_raw_time;
        n_stable_time = r_stable_time;
        n_start_time  = r_start_time;
        w_event       = 1'b0;
        if (i_cmd == sbq_pkg::CMD_START) begin
            n_started     = 1'b1;
            n_raw         = i_lvl;
            n_stable      = i_lvl;
            n_armed       = !i_lvl;
            n_pending     = 1'b0;
            n_raw_time    = i_now;
            n_stable_time = i_now;
            n_start_time  = i_now;
        end else if (r_started) begin
            n_raw = i_lvl;
            if (w_changed) begin
                n_raw_time = i_now;
            end
            if (w_flip) begin
                n_stable      = i_lvl;
                n_stable_time = i_now;
            end
            if (w_disarm) begin
                // An immediate event leaves any older pending event standing.
                n_armed   = 1'b0;
                n_pending = r_pending || !w_e_guard;
                w_event   = w_e_guard;
            end else begin
                n_armed   = r_armed || (!n_stable && w_e_rearm);
                n_pending = r_pending && !w_e_guard;
                w_event   = r_pending && w_e_guard;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started     <= 1'b0;
            r_raw         <= 1'b0;
            r_stable      <= 1'b0;
            r_armed       <= 1'b0;
            r_pending     <= 1'b0;
            r_raw_time    <= '0;
            r_stable_time <= '0;
            r_start_time  <= '0;
        end else if (i_adv) begin
            r_started     <= n_started;
            r_raw         <= n_raw;
            r_stable      <= n_stable;
            r_armed       <= n_armed;
            r_pending     <= n_pending;
            r_raw_time    <= n_raw_time;
            r_stable_time <= n_stable_time;
            r_start_time  <= n_start_time;
        end
    end

    assign o_result.start_event       = w_event;
    assign o_result.debounced_pressed = n_stable;
    assign o_result.is_armed          = n_armed;

endmodule

`default_nettype wire

/* rtl/start_button_qualifier.sv */
// Top level of the start button qualifier: input register, result register
// and stream handshakes. Depends on sbq_pkg, sbq_cfg and sbq_core.
//
//  Channel   Direction  Handshake             Payload
//  s_axis    in         tvalid / tready       tuser: command; tdata: level_pressed, now_us
//  m_axis    out        tvalid / tready       tdata: start_event, debounced_pressed, is_armed
//  cfg       in         write enable only     index 0..2, 16-bit millisecond value
//
// Every transfer on the input side yields exactly one transfer on the output
// side, via the input register and then the result register. The block
// sustains one item per clock unless the output stalls: the input register
// feeds the state update, one pass of 48-bit subtract-and-compare logic, and
// the result lands in the output register. Reset is synchronous, active low;
// it restores register defaults and clears all qualification state. A stall
// on the output holds the result register; an empty input register takes one more.
`timescale 1ns / 1ps
`default_nettype none

module start_button_qualifier #(
    parameter int TIME_BITS = sbq_pkg::TIME_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Configuration write port.
    input  wire                              i_cfg_we,
    input  wire  [sbq_pkg::IDX_W-1:0]        i_cfg_index,
    input  wire  [sbq_pkg::CFG_W-1:0]        i_cfg_wdata,
    // Input stream.
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata, lowest bit up: level_pressed, now_us, zero pad to whole bytes.
    input  wire  [((TIME_BITS+8)/8)*8-1:0]   i_s_axis_tdata,
    // tuser: command (0 = level sample, 1 = start).
    input  wire                              i_s_axis_tuser,
    // Output stream.
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // tdata, lowest bit up: start_event, debounced_pressed, is_armed, zero pad.
    output logic [sbq_pkg::OUT_W-1:0]        o_m_axis_tdata
);

    sbq_pkg::t_thresh     w_thresh;
    sbq_pkg::t_result     w_result;

    // Input register stage.
    logic                 r_in_valid;
    logic                 r_in_cmd;
    logic                 r_in_lvl;
    logic [TIME_BITS-1:0] r_in_now;

    // Result register stage.
    logic                 r_out_valid;
    sbq_pkg::t_result     r_out;

    logic w_out_free, w_adv, w_in_take;

    // The result register can load when empty or when it empties this cycle.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    sbq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_thresh    (w_thresh)
    );

    sbq_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_cmd    (r_in_cmd),
        .i_lvl    (r_in_lvl),
        .i_now    (r_in_now),
        .i_thresh (w_thresh),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_cmd <= i_s_axis_tuser;
            r_in_lvl <= i_s_axis_tdata[0];
            r_in_now <= i_s_axis_tdata[TIME_BITS:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(sbq_pkg::OUT_W - 3){1'b0}}, r_out};

endmodule

`default_nettype wire
